// File: rtl/core/assert_macros.svh
// Assertion macros for the grid line collision check RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// File: rtl/core/glcc_pkg.sv
// Types and constants of the grid line collision check.
// No dependencies; imported by every module of the block but glcc_ram.
package glcc_pkg;

  localparam int COORD_W  = 7;
  localparam int ERR_W    = 11;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 8;

  typedef logic [COORD_W-1:0]        coord_t;
  typedef logic signed [ERR_W-1:0]   err_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_CHECK = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [S_DATA_W-4*COORD_W-2:0] pad;
    logic                          cell_value;
    coord_t                        end_y;
    coord_t                        end_x;
    coord_t                        start_y;
    coord_t                        start_x;
  } s_item_t;

  typedef struct packed {
    logic clr_en;
    logic wr_en;
    logic load;
    logic step;
    logic latch;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic issued_last;
    logic done;
  } sts_t;

endpackage

// File: rtl/core/glcc_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module glcc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/glcc_ctrl.sv
// Controller of the grid line collision check: clear pass, item intake, walk, result hand-off.
// Depends on glcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module glcc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  input  glcc_pkg::kind_e s_kind_i,
  output logic            s_tready_o,
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  output glcc_pkg::cmd_t  cmd_o,
  input  glcc_pkg::sts_t  sts_i
);
  import glcc_pkg::*;

  state_e state_q, state_d;
  logic   m_tvalid_q, m_tvalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          if (s_kind_i == KIND_CHECK) begin
            cmd_o.load = 1'b1;
            state_d    = ST_WALK;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      ST_WALK: begin
        cmd_o.step = !sts_i.issued_last;
        if (sts_i.done) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
    endcase
    m_tvalid_d = cmd_o.out_load || (m_tvalid_q && !m_tready_i);
  end

  assign m_tvalid_o = m_tvalid_q;

  `ASSERT_NEVER(a_out_overwrite, clk_i, rst_ni, cmd_o.out_load && m_tvalid_q && !m_tready_i, "result register overwritten")
  `ASSERT_PROP(a_check_walks, clk_i, rst_ni, (s_tvalid_i && s_tready_o && s_kind_i == KIND_CHECK) |=> (state_q == ST_WALK), "check item did not start a walk")
  `ASSERT_PROP(a_clear_complete, clk_i, rst_ni, $fell(state_q == ST_CLEAR) |-> $past(sts_i.clear_last), "clear pass left early")

endmodule

// File: rtl/core/glcc_dp.sv
// Datapath of the grid line collision check: Bresenham stepper, grid memory, result registers.
// Depends on glcc_pkg and glcc_ram.
module glcc_dp #(
  parameter int GRID_DIM = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  glcc_pkg::s_item_t               item_i,
  input  glcc_pkg::cmd_t                  cmd_i,
  output glcc_pkg::sts_t                  sts_o,
  output logic [glcc_pkg::M_DATA_W-1:0]   m_tdata_o
);
  import glcc_pkg::*;

  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic in_grid(coord_t col, coord_t row);
    return (32'(col) < GRID_DIM) && (32'(row) < GRID_DIM);
  endfunction

  function automatic logic [AW-1:0] cell_addr(coord_t col, coord_t row);
    return AW'(32'(col) * 32'(GRID_DIM) + 32'(row));
  endfunction

  coord_t        x_q, y_q, x1_q, y1_q;
  err_t          dx_q, dy_q, err_q;
  logic          sx_neg_q, sy_neg_q;
  logic          issued_last_q;
  logic          rd_v_q, oob_q, last_q;
  logic          result_q, blocked_q;
  logic [AW-1:0] clr_cnt_q;

  logic [COORD_W-1:0] dx_u, dy_u;
  err_t               e2, err_d;
  logic               cx, cy, at_end, hit;
  logic               ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]      ram_addr;

  assign dx_u = (item_i.end_x > item_i.start_x) ? item_i.end_x - item_i.start_x
                                                : item_i.start_x - item_i.end_x;
  assign dy_u = (item_i.end_y > item_i.start_y) ? item_i.end_y - item_i.start_y
                                                : item_i.start_y - item_i.end_y;

  assign e2     = err_q <<< 1;
  assign cx     = (e2 >= dy_q);
  assign cy     = (e2 <= dx_q);
  assign err_d  = err_q + (cx ? dy_q : err_t'(0)) + (cy ? dx_q : err_t'(0));
  assign at_end = (x_q == x1_q) && (y_q == y1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issued_last_q <= 1'b0;
      rd_v_q        <= 1'b0;
      clr_cnt_q     <= '0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.load) begin
        issued_last_q <= 1'b0;
        rd_v_q        <= 1'b0;
      end else begin
        rd_v_q <= cmd_i.step;
        if (cmd_i.step && at_end) begin
          issued_last_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q      <= item_i.start_x;
      y_q      <= item_i.start_y;
      x1_q     <= item_i.end_x;
      y1_q     <= item_i.end_y;
      dx_q     <= err_t'({1'b0, dx_u});
      dy_q     <= -err_t'({1'b0, dy_u});
      err_q    <= err_t'({1'b0, dx_u}) - err_t'({1'b0, dy_u});
      sx_neg_q <= !(item_i.start_x < item_i.end_x);
      sy_neg_q <= !(item_i.start_y < item_i.end_y);
    end else if (cmd_i.step) begin
      oob_q  <= !in_grid(x_q, y_q);
      last_q <= at_end;
      if (!at_end) begin
        err_q <= err_d;
        if (cx) begin
          x_q <= sx_neg_q ? x_q - COORD_W'(1) : x_q + COORD_W'(1);
        end
        if (cy) begin
          y_q <= sy_neg_q ? y_q - COORD_W'(1) : y_q + COORD_W'(1);
        end
      end
    end
    if (cmd_i.latch) begin
      result_q <= hit;
    end
    if (cmd_i.out_load) begin
      blocked_q <= result_q;
    end
  end

  always_comb begin
    priority if (cmd_i.clr_en) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_q;
      ram_wdata = 1'b0;
    end else if (cmd_i.wr_en) begin
      ram_we    = in_grid(item_i.start_x, item_i.start_y);
      ram_addr  = cell_addr(item_i.start_x, item_i.start_y);
      ram_wdata = item_i.cell_value;
    end else begin
      ram_we    = 1'b0;
      ram_addr  = cell_addr(x_q, y_q);
      ram_wdata = 1'b0;
    end
  end

  glcc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign hit = rd_v_q && ram_rdata && !oob_q;

  assign sts_o.clear_last  = (clr_cnt_q == AW'(DEPTH - 1));
  assign sts_o.issued_last = issued_last_q;
  assign sts_o.done        = rd_v_q && (hit || last_q);

  assign m_tdata_o = M_DATA_W'(blocked_q);

endmodule

// File: rtl/core/grid_line_collision_check.sv
// Grid line collision check. After reset a clearing pass over all GRID_DIM*GRID_DIM cells
// zeroes the grid memory with s_axis_tready low. A write item gives no result.
// A check item over a line of n cells (n <= 128) reads one cell per cycle from the grid
// memory port until the last cell or a hit. The result is registered for the master port
// once any earlier result is accepted; the next item is taken as m_axis_tvalid rises.
// Reset is asynchronous, active low, and clears all control state.
module grid_line_collision_check #(
  parameter int GRID_DIM = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_x[6:0], start_y[13:7], end_x[20:14], end_y[27:21], cell_value[28], zero[31:29]
  input  logic [glcc_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // kind[0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // blocked[0], zero[7:1]
  output logic [glcc_pkg::M_DATA_W-1:0]   m_axis_tdata
);
  import glcc_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  s_item_t item;
  kind_e   kind;

  assign item = s_item_t'(s_axis_tdata);
  assign kind = kind_e'(s_axis_tuser);

  glcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_kind_i   (kind),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  glcc_dp #(
    .GRID_DIM (GRID_DIM)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .m_tdata_o (m_axis_tdata)
  );

endmodule
